>>> design/stp_pkg.sv
// Shared types, constants and a function for the stepper phase sequencer.
package stp_pkg;

    // Field widths.
    localparam int POS_W      = 16;
    localparam int INTERVAL_W = 26;
    localparam int COUNT_W    = 32;
    localparam int REMAIN_W   = 31;
    localparam int COIL_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 26;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_REV = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_INTERVAL = 2'd1;

    // Register reset values.
    localparam logic [POS_W-1:0]      SPR_RESET      = 16'd200;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 26'd5000;

    // Saturation limits.
    localparam logic [INTERVAL_W-1:0] ELAPSED_MAX = {INTERVAL_W{1'b1}};
    localparam logic [REMAIN_W-1:0]   REMAIN_MAX  = {REMAIN_W{1'b1}};

    // Item commands.
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_MOVE = 1'b1;

    typedef struct packed {
        logic                      cmd;
        logic signed [COUNT_W-1:0] step_count;
    } t_in_item;

    typedef struct packed {
        logic [COIL_W-1:0] coils;
        logic              busy_res;
        logic [POS_W-1:0]  position;
        logic              stepped;
    } t_out_item;

    typedef struct packed {
        logic [POS_W-1:0]      steps_per_rev;
        logic [INTERVAL_W-1:0] step_interval_us;
    } t_cfg;

    // Full-step coil pattern for each of the four phases.
    function automatic logic [COIL_W-1:0] phase_coils(input logic [1:0] phase);
        logic [COIL_W-1:0] c;
        unique case (phase)
            2'd0:    c = 4'd5;
            2'd1:    c = 4'd6;
            2'd2:    c = 4'd10;
            default: c = 4'd9;
        endcase
        return c;
    endfunction

endpackage

>>> design/stp_core.sv
// Motion state and the per-item step logic of the stepper phase sequencer.
module stp_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  stp_pkg::t_in_item i_item,
    input  stp_pkg::t_cfg     i_cfg,
    output stp_pkg::t_out_item o_result
);
    import stp_pkg::*;

    logic [POS_W-1:0]      r_position, n_position;
    logic [REMAIN_W-1:0]   r_remaining, n_remaining;
    logic                  r_forward, n_forward;
    logic [INTERVAL_W-1:0] r_elapsed, n_elapsed;
    logic [COIL_W-1:0]     r_coils, n_coils;

    logic [COUNT_W-1:0]    raw;
    logic [COUNT_W-1:0]    mag;
    logic [INTERVAL_W-1:0] elapsed_inc;
    logic [POS_W:0]        pos_plus;
    logic [POS_W-1:0]      pos_step;
    logic                  do_step;

    assign raw = i_item.step_count;
    assign mag = raw[COUNT_W-1] ? (~raw + 1'b1) : raw;

    // Saturating tick counter and the step decision.
    assign elapsed_inc = (r_elapsed != ELAPSED_MAX) ? r_elapsed + 1'b1 : r_elapsed;
    assign do_step = (i_item.cmd == CMD_TICK) && (r_remaining != '0)
                     && (elapsed_inc >= i_cfg.step_interval_us);

    // Next position, wrapping within one revolution.
    assign pos_plus = {1'b0, r_position} + 1'b1;
    always_comb begin
        if (i_cfg.steps_per_rev == '0) begin
            pos_step = '0;
        end else if (r_forward) begin
            pos_step = (pos_plus >= {1'b0, i_cfg.steps_per_rev}) ? '0 : pos_plus[POS_W-1:0];
        end else if (r_position == '0 || r_position >= i_cfg.steps_per_rev) begin
            pos_step = i_cfg.steps_per_rev - 1'b1;
        end else begin
            pos_step = r_position - 1'b1;
        end
    end

    // Next state for the item in hand.
    always_comb begin
        n_position  = r_position;
        n_remaining = r_remaining;
        n_forward   = r_forward;
        n_elapsed   = r_elapsed;
        n_coils     = r_coils;
        if (i_item.cmd == CMD_MOVE) begin
            if (raw != '0) begin
                n_forward   = ~raw[COUNT_W-1];
                n_remaining = mag[COUNT_W-1] ? REMAIN_MAX : mag[REMAIN_W-1:0];
            end
        end else if (do_step) begin
            n_elapsed   = '0;
            n_position  = pos_step;
            n_remaining = r_remaining - 1'b1;
            n_coils     = phase_coils(pos_step[1:0]);
        end else begin
            n_elapsed   = elapsed_inc;
        end
    end

    // State registers advance once per processed item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position  <= '0;
            r_remaining <= '0;
            r_forward   <= 1'b0;
            r_elapsed   <= '0;
            r_coils     <= '0;
        end else if (i_fire) begin
            r_position  <= n_position;
            r_remaining <= n_remaining;
            r_forward   <= n_forward;
            r_elapsed   <= n_elapsed;
            r_coils     <= n_coils;
        end
    end

    // Result reflects the state after this item.
    always_comb begin
        o_result.coils    = n_coils;
        o_result.busy_res = (n_remaining != '0);
        o_result.position = n_position;
        o_result.stepped  = do_step;
    end

endmodule

>>> design/stepper_phase_sequencer.sv
// Stepper phase sequencer: input register, step core, result register.
// An item passes the input register, then the result register; a full result register holds it back.
// Throughput: one item per cycle while the result side is ready.
// The result register lets a new item enter while a result waits.
// Synchronous active-low reset clears motion state, valid flags and
// restores the registers to 200 steps per revolution and 5000 us.
module stepper_phase_sequencer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  stp_pkg::t_in_item                 i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output stp_pkg::t_out_item                o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [stp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [stp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import stp_pkg::*;

    logic      r_in_vld;
    t_in_item  r_in;
    logic      r_out_vld;
    t_out_item r_out;
    t_cfg      r_cfg;
    t_out_item result;
    logic      fire;

    // Process the held item when the result register is free or draining.
    assign fire       = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || fire;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in;
        end
    end

    // Configuration registers, always ready for a transfer.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.steps_per_rev    <= SPR_RESET;
            r_cfg.step_interval_us <= INTERVAL_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_STEPS_PER_REV) begin
                r_cfg.steps_per_rev <= i_cfg_data[POS_W-1:0];
            end else if (i_cfg_index == CFG_STEP_INTERVAL) begin
                r_cfg.step_interval_us <= i_cfg_data[INTERVAL_W-1:0];
            end
        end
    end

    stp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    // A step always drives the coil pattern of the new phase.
    a_step_coils: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.stepped |-> o_out.coils == phase_coils(o_out.position[1:0]))
        else $error("coil pattern does not match stepped position");

    // A move never steps.
    a_move_no_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_in.cmd == CMD_MOVE |=> !o_out.stepped)
        else $error("move item reported a step");

    // A nonzero move leaves the motor busy.
    a_move_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_in.cmd == CMD_MOVE && r_in.step_count != '0 |=> o_out.busy_res)
        else $error("nonzero move did not set busy");

    // A processed item always yields a valid result.
    a_fire_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_out_valid)
        else $error("processed item produced no result");

endmodule

>>> tb/sv/stepper_phase_sequencer_test.sv
// Self-checking testbench for the stepper phase sequencer: directed table, then random register writes and items.
module stepper_phase_sequencer_test;

    timeunit 1ns;
    timeprecision 1ps;

    import stp_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 900;
    localparam int TAIL_CYCLES   = 4;
    localparam int REPORT_LIMIT  = 10;

    // Register indexes that the block has no register behind.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    // Full-step coil drive for phases 0 to 3.
    localparam logic [COIL_W-1:0] COIL_PATTERN [4] = '{4'd5, 4'd6, 4'd10, 4'd9};

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    // One line of the directed table: a register write or an item, optionally with
    // the result it must produce.
    typedef struct packed {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   index;
        logic [CFG_DATA_W-1:0]  data;
        t_in_item               item;
        logic                   known;
        t_out_item              result;
    } t_row;

    logic                  i_clk     = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_item              in_item   = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_ready;
    logic                  out_valid;
    t_out_item             out_item;
    logic                  cfg_ready;

    // Motor state as the block should hold it.
    logic [POS_W-1:0]      motor_spr      = SPR_RESET;
    logic [INTERVAL_W-1:0] motor_interval = INTERVAL_RESET;
    logic [POS_W-1:0]      motor_pos      = '0;
    logic [REMAIN_W-1:0]   motor_remain   = '0;
    logic                  motor_fwd      = 1'b0;
    logic [INTERVAL_W-1:0] motor_elapsed  = '0;
    logic [COIL_W-1:0]     motor_coils    = '0;

    t_out_item expected_results [$];
    int        mismatches = 0;
    int        items_sent = 0;
    int        cycles     = 0;
    bit        steady     = 1'b0;

    stepper_phase_sequencer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Position after one step in the current direction, wrapping at the revolution.
    function automatic logic [POS_W-1:0] neighbor_pos(logic [POS_W-1:0] pos);
        logic [POS_W:0] up;
        up = {1'b0, pos} + 17'd1;
        if (motor_spr == '0) return '0;
        if (motor_fwd) return (up >= {1'b0, motor_spr}) ? '0 : up[POS_W-1:0];
        if (pos == '0 || pos >= motor_spr) return motor_spr - 16'd1;
        return pos - 16'd1;
    endfunction

    // Advances the motor state by one item and returns the result it produces.
    function automatic t_out_item step_motor(t_in_item it);
        t_out_item r;
        logic [COUNT_W-1:0] mag;
        r = '0;
        if (it.cmd == CMD_MOVE) begin
            if (it.step_count != '0) begin
                if (it.step_count[COUNT_W-1]) begin
                    mag = ~it.step_count + 32'd1;
                    motor_fwd = 1'b0;
                end else begin
                    mag = it.step_count;
                    motor_fwd = 1'b1;
                end
                if (mag > {1'b0, REMAIN_MAX}) mag = {1'b0, REMAIN_MAX};
                motor_remain = mag[REMAIN_W-1:0];
            end
        end else begin
            if (motor_elapsed != ELAPSED_MAX) motor_elapsed = motor_elapsed + 26'd1;
            if (motor_remain != '0 && motor_elapsed >= motor_interval) begin
                motor_elapsed = '0;
                motor_pos     = neighbor_pos(motor_pos);
                motor_remain  = motor_remain - 31'd1;
                motor_coils   = COIL_PATTERN[motor_pos[1:0]];
                r.stepped     = 1'b1;
            end
        end
        r.coils    = motor_coils;
        r.busy_res = (motor_remain != '0);
        r.position = motor_pos;
        return r;
    endfunction

    function automatic t_row item_row(logic cmd, logic signed [COUNT_W-1:0] cnt);
        t_row r;
        r = '0;
        r.kind = ROW_ITEM;
        r.item.cmd = cmd;
        r.item.step_count = cnt;
        return r;
    endfunction

    function automatic t_row known_row(logic cmd, logic signed [COUNT_W-1:0] cnt,
                                       logic [COIL_W-1:0] coils, logic busy,
                                       logic [POS_W-1:0] pos, logic stepped);
        t_row r;
        r = item_row(cmd, cnt);
        r.known = 1'b1;
        r.result.coils = coils;
        r.result.busy_res = busy;
        r.result.position = pos;
        r.result.stepped = stepped;
        return r;
    endfunction

    function automatic t_row reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        t_row r;
        r = '0;
        r.kind = ROW_CFG;
        r.index = idx;
        r.data = data;
        return r;
    endfunction

    function automatic void note_failure(string what);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) $display("%s", what);
    endfunction

    // Sends one item, with a random gap in front outside the steady stretch, and records its expected result.
    task automatic push_item(t_in_item it, logic known, t_out_item result);
        int gap;
        t_out_item predicted;
        gap = 0;
        if (cfg_valid) cfg_valid <= 1'b0;
        if (!steady) while ($urandom_range(0, 99) < 26) gap++;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (!in_ready);
        predicted = step_motor(it);
        expected_results.push_back(known ? result : predicted);
        items_sent++;
    endtask

    // Writes one register once every pending result has come back.
    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        if (in_valid) in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!cfg_ready);
        case (idx)
            CFG_STEPS_PER_REV: motor_spr = data[POS_W-1:0];
            CFG_STEP_INTERVAL: motor_interval = data[INTERVAL_W-1:0];
            default: ;
        endcase
    endtask

    // The result side stalls at random, except during the steady stretch.
    always @(posedge i_clk) out_ready <= steady || ($urandom_range(0, 99) >= 26);

    // Each result transfer is matched against the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                note_failure($sformatf("unexpected result: coils=%0d busy=%0b pos=%0d stepped=%0b",
                             out_item.coils, out_item.busy_res, out_item.position,
                             out_item.stepped));
            end else begin
                want = expected_results.pop_front();
                if (out_item.coils !== want.coils || out_item.busy_res !== want.busy_res ||
                    out_item.position !== want.position || out_item.stepped !== want.stepped)
                begin
                    note_failure($sformatf({"result mismatch: expected coils=%0d busy=%0b ",
                                 "pos=%0d stepped=%0b, got coils=%0d busy=%0b pos=%0d ",
                                 "stepped=%0b"}, want.coils, want.busy_res, want.position,
                                 want.stepped, out_item.coils, out_item.busy_res,
                                 out_item.position, out_item.stepped));
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        t_row plan [$];
        t_in_item it;
        logic [CFG_DATA_W-1:0] d;
        int pick;
        int cnt;
        int phase;
        int target;

        // Directed table: reset values, zero and extreme counts, interval zero,
        // wrapping, positions left beyond a shrunk revolution, zero steps per
        // revolution, the largest interval and writes to unused indexes.
        plan = '{
            known_row(CMD_TICK, 32'sd0, 4'd0, 1'b0, 16'd0, 1'b0),
            known_row(CMD_MOVE, 32'sd0, 4'd0, 1'b0, 16'd0, 1'b0),
            reg_row(CFG_STEP_INTERVAL, 26'd0),
            known_row(CMD_MOVE, -32'sd1, 4'd0, 1'b1, 16'd0, 1'b0),
            known_row(CMD_TICK, 32'sd0, 4'd9, 1'b0, 16'd199, 1'b1),
            known_row(CMD_TICK, 32'sd0, 4'd9, 1'b0, 16'd199, 1'b0),
            known_row(CMD_MOVE, 32'h8000_0000, 4'd9, 1'b1, 16'd199, 1'b0),
            item_row(CMD_MOVE, 32'h7FFF_FFFF),
            item_row(CMD_TICK, 32'sd0),
            reg_row(CFG_STEPS_PER_REV, 26'd65535),
            item_row(CMD_MOVE, -32'sd1),
            item_row(CMD_TICK, 32'sd0),
            reg_row(CFG_STEPS_PER_REV, 26'd3),
            item_row(CMD_MOVE, 32'sd1),
            item_row(CMD_TICK, 32'sd0),
            reg_row(CFG_STEPS_PER_REV, 26'd65535),
            item_row(CMD_MOVE, -32'sd1),
            item_row(CMD_TICK, 32'sd0),
            reg_row(CFG_STEPS_PER_REV, 26'd3),
            item_row(CMD_MOVE, -32'sd1),
            item_row(CMD_TICK, 32'sd0),
            reg_row(CFG_STEPS_PER_REV, 26'd0),
            item_row(CMD_MOVE, 32'sd2),
            item_row(CMD_TICK, 32'sd0),
            item_row(CMD_TICK, 32'sd0),
            reg_row(CFG_STEP_INTERVAL, 26'h3FF_FFFF),
            reg_row(CFG_SPARE_A, 26'h155),
            reg_row(CFG_SPARE_B, 26'h2AA),
            item_row(CMD_MOVE, 32'sd3),
            item_row(CMD_TICK, 32'sd0),
            reg_row(CFG_STEP_INTERVAL, 26'd1),
            item_row(CMD_TICK, 32'sd0),
            item_row(CMD_TICK, 32'sd0)
        };

        repeat (9) @(posedge i_clk);
        rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) write_cfg(plan[i].index, plan[i].data);
            else push_item(plan[i].item, plan[i].known, plan[i].result);
        end

        // Random phases: new settings, then a burst of ticks with moves mixed in.
        phase  = 0;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            steady = (phase == 3 || phase == 4);

            pick = $urandom_range(0, 9);
            d = 26'($urandom);
            if (pick == 0) d[POS_W-1:0] = $urandom_range(0, 1) ? 16'd0 : 16'hFFFF;
            else if (pick > 2) d[POS_W-1:0] = 16'($urandom_range(1, 8));
            if ($urandom_range(0, 4) != 0) write_cfg(CFG_STEPS_PER_REV, d);

            pick = $urandom_range(0, 9);
            if (pick <= 5) d = 26'($urandom_range(0, 12));
            else if (pick <= 7) d = 26'($urandom_range(13, 300));
            else if (pick == 8) d = 26'($urandom);
            else d = $urandom_range(0, 1) ? 26'h3FF_FFFF : 26'd60000000;
            if ($urandom_range(0, 4) != 0) write_cfg(CFG_STEP_INTERVAL, d);

            if ($urandom_range(0, 3) == 0)
                write_cfg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, 26'($urandom));

            repeat ($urandom_range(30, 90)) begin
                it.cmd = ($urandom_range(0, 99) < 15) ? CMD_MOVE : CMD_TICK;
                it.step_count = $urandom;
                if (it.cmd == CMD_MOVE) begin
                    pick = $urandom_range(0, 19);
                    if (pick < 12) begin
                        cnt = int'($urandom_range(1, 40));
                        if ($urandom_range(0, 1) != 0) cnt = -cnt;
                        it.step_count = cnt;
                    end else if (pick < 14) begin
                        it.step_count = 32'sd0;
                    end else if (pick == 17) begin
                        it.step_count = 32'h8000_0000;
                    end else if (pick == 18) begin
                        it.step_count = 32'h7FFF_FFFF;
                    end else if (pick == 19) begin
                        it.step_count = 32'h8000_0001;
                    end
                end
                push_item(it, 1'b0, '0);
            end
            phase++;
        end
        steady = 1'b0;

        // Drain, then give any stray result time to show up.
        if (in_valid) in_valid <= 1'b0;
        if (cfg_valid) cfg_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
